// File: rtl/core/npc_pkg.sv
// Shared types and constants for the non-overlapping pattern counter.
// No dependencies; compiled first.
`default_nettype none

package npc_pkg;

    // Needle and window geometry
    localparam int MAX_NEEDLE  = 16;
    localparam int WIN_DEPTH   = MAX_NEEDLE - 1;
    localparam int LEN_W       = $clog2(MAX_NEEDLE + 1);
    localparam int SKIP_W      = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int IDX_W       = SKIP_W;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int NEEDLE_W    = 2 * CFG_DATA_W;

    // Queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd2;

    localparam logic [LEN_W-1:0] NEEDLE_LENGTH_RESET = LEN_W'(1);

    // Work kinds handed from front to back
    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,
        OP_EOF      = 2'd1,
        OP_BYTE_EOF = 2'd2
    } npc_op_t;

    typedef struct packed {
        npc_op_t            op;
        logic [BYTE_W-1:0]  data_byte;
    } npc_entry_t;

    // Queue read side as seen by the back end
    typedef struct packed {
        logic       valid;
        npc_entry_t entry;
    } npc_queue_out_t;

endpackage

`default_nettype wire

// File: rtl/core/npc_if.sv
// Channel interfaces: input stream, result, configuration write.
// Depends on npc_pkg.
`default_nettype none

interface npc_stream_if;
    logic                       valid;
    logic                       ready;
    logic [npc_pkg::BYTE_W-1:0] data_byte;
    logic                       byte_present;
    logic                       end_of_file;

    modport source (output valid, data_byte, byte_present, end_of_file, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_file, output ready);
endinterface

interface npc_result_if;
    logic                        valid;
    logic                        ready;
    logic [npc_pkg::COUNT_W-1:0] match_count;

    modport source (output valid, match_count, input ready);
    modport sink   (input valid, match_count, output ready);
endinterface

interface npc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [npc_pkg::CFG_IDX_W-1:0]  index;
    logic [npc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/npc_front.sv
// Front end: accepts stream words, drops bare idle words, classifies the rest.
// Depends on npc_pkg and npc_if.
`default_nettype none

module npc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    npc_stream_if.sink         stream,
    input  wire logic          queue_full,
    output logic               push,
    output npc_pkg::npc_entry_t push_entry
);

    logic                 front_valid_reg;
    logic                 front_valid_next;
    npc_pkg::npc_entry_t  front_entry_reg;
    npc_pkg::npc_entry_t  front_entry_next;
    logic                 accept;
    logic                 useful;

    // Holding stage frees as soon as the queue takes its word
    assign stream.ready = !front_valid_reg || !queue_full;
    assign accept       = stream.valid && stream.ready;
    assign useful       = stream.byte_present || stream.end_of_file;
    assign push         = front_valid_reg && !queue_full;
    assign push_entry   = front_entry_reg;

    // Classify the incoming word
    always_comb
    begin
        front_entry_next           = front_entry_reg;
        front_entry_next.data_byte = stream.data_byte;
        priority if (stream.byte_present && stream.end_of_file)
        begin
            front_entry_next.op = npc_pkg::OP_BYTE_EOF;
        end
        else if (stream.end_of_file)
        begin
            front_entry_next.op = npc_pkg::OP_EOF;
        end
        else
        begin
            front_entry_next.op = npc_pkg::OP_BYTE;
        end
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept && useful)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && useful)
        begin
            front_entry_reg <= front_entry_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/npc_queue.sv
// Short flop queue between front and back ends.
// Depends on npc_pkg.
`default_nettype none

module npc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  npc_pkg::npc_entry_t       push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output npc_pkg::npc_queue_out_t   head
);

    npc_pkg::npc_entry_t             entry_reg [npc_pkg::QUEUE_DEPTH];
    logic [npc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [npc_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [npc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [npc_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [npc_pkg::QCNT_W-1:0]      count_reg;
    logic [npc_pkg::QCNT_W-1:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full       = (count_reg == npc_pkg::QCNT_W'(npc_pkg::QUEUE_DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.entry = entry_reg[rd_ptr_reg];

    // Pointers wrap naturally at a power-of-two depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/npc_back.sv
// Back end: needle registers, byte window compare, skip counter, count and
// result register. Depends on npc_pkg and npc_if.
`default_nettype none

module npc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    npc_cfg_if.sink                  cfg,
    input  npc_pkg::npc_queue_out_t  head,
    output logic                     pop,
    npc_result_if.source             result
);

    localparam logic [npc_pkg::LEN_W-1:0]   LEN_MAX   = npc_pkg::LEN_W'(npc_pkg::MAX_NEEDLE);
    localparam logic [npc_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration
    logic [npc_pkg::CFG_DATA_W-1:0] needle_low_reg;
    logic [npc_pkg::CFG_DATA_W-1:0] needle_high_reg;
    logic [npc_pkg::LEN_W-1:0]      needle_length_reg;

    // Scan state
    logic [npc_pkg::BYTE_W-1:0]     window_reg [npc_pkg::WIN_DEPTH];
    logic [npc_pkg::LEN_W-1:0]      seen_reg;
    logic [npc_pkg::LEN_W-1:0]      seen_next;
    logic [npc_pkg::SKIP_W-1:0]     skip_reg;
    logic [npc_pkg::SKIP_W-1:0]     skip_next;
    logic [npc_pkg::COUNT_W-1:0]    count_reg;
    logic [npc_pkg::COUNT_W-1:0]    count_next;
    logic [npc_pkg::COUNT_W-1:0]    count_after;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [npc_pkg::COUNT_W-1:0]    out_count_reg;

    logic [npc_pkg::NEEDLE_W-1:0]   needle_all;
    logic [npc_pkg::BYTE_W-1:0]     hist [npc_pkg::MAX_NEEDLE];
    logic [npc_pkg::MAX_NEEDLE-1:0] pos_ok;
    logic [npc_pkg::LEN_W-1:0]      len_eff;
    logic [npc_pkg::IDX_W-1:0]      len_m1;
    logic [npc_pkg::LEN_W-1:0]      seen_inc;
    logic                           hit;
    logic                           has_byte;
    logic                           has_eof;
    logic                           take_byte;

    assign cfg.ready = 1'b1;

    // Configuration writes; indexes outside the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
            needle_length_reg <= npc_pkg::NEEDLE_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                npc_pkg::REG_NEEDLE_LOW:    needle_low_reg    <= cfg.data;
                npc_pkg::REG_NEEDLE_HIGH:   needle_high_reg   <= cfg.data;
                npc_pkg::REG_NEEDLE_LENGTH: needle_length_reg <= cfg.data[npc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the queued word
    always_comb
    begin
        unique case (head.entry.op)
            npc_pkg::OP_BYTE:
            begin
                has_byte = 1'b1;
                has_eof  = 1'b0;
            end
            npc_pkg::OP_EOF:
            begin
                has_byte = 1'b0;
                has_eof  = 1'b1;
            end
            npc_pkg::OP_BYTE_EOF:
            begin
                has_byte = 1'b1;
                has_eof  = 1'b1;
            end
            default:
            begin
                has_byte = 1'b0;
                has_eof  = 1'b0;
            end
        endcase
    end

    // An end-of-file word waits for room in the result register
    assign pop       = head.valid && (!has_eof || !out_valid_reg || result.ready);
    assign take_byte = pop && has_byte;

    // Effective length: zero acts as one, too large acts as the maximum
    always_comb
    begin
        priority if (needle_length_reg == '0)
        begin
            len_eff = npc_pkg::LEN_W'(1);
        end
        else if (needle_length_reg > LEN_MAX)
        begin
            len_eff = LEN_MAX;
        end
        else
        begin
            len_eff = needle_length_reg;
        end
    end
    assign len_m1     = npc_pkg::IDX_W'(len_eff - 1'b1);
    assign needle_all = {needle_high_reg, needle_low_reg};
    assign seen_inc   = (seen_reg == LEN_MAX) ? seen_reg : seen_reg + 1'b1;

    // History: newest byte first, then the window
    always_comb
    begin
        hist[0] = head.entry.data_byte;
        for (int j = 1; j < npc_pkg::MAX_NEEDLE; j++)
        begin
            hist[j] = window_reg[j-1];
        end
    end

    // Needle byte k lines up with the byte len-1-k places back
    always_comb
    begin
        for (int k = 0; k < npc_pkg::MAX_NEEDLE; k++)
        begin
            if (npc_pkg::LEN_W'(k) >= len_eff)
            begin
                pos_ok[k] = 1'b1;
            end
            else
            begin
                pos_ok[k] = (hist[len_m1 - npc_pkg::IDX_W'(k)]
                             == needle_all[k*npc_pkg::BYTE_W +: npc_pkg::BYTE_W]);
            end
        end
    end
    assign hit = (&pos_ok) && (seen_inc >= len_eff);

    // Skip counter and count update for one byte
    always_comb
    begin
        seen_next   = seen_reg;
        skip_next   = skip_reg;
        count_after = count_reg;
        if (take_byte)
        begin
            seen_next = seen_inc;
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - 1'b1;
            end
            else if (hit)
            begin
                skip_next = len_m1;
                if (count_reg != COUNT_MAX)
                begin
                    count_after = count_reg + 1'b1;
                end
            end
        end
        count_next = count_after;
        // End of file clears the scan; window contents are gated by seen
        if (pop && has_eof)
        begin
            seen_next  = '0;
            skip_next  = '0;
            count_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && has_eof)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            skip_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            skip_reg      <= skip_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Window shift and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            window_reg[0] <= head.entry.data_byte;
            for (int j = 1; j < npc_pkg::WIN_DEPTH; j++)
            begin
                window_reg[j] <= window_reg[j-1];
            end
        end
        if (pop && has_eof)
        begin
            out_count_reg <= count_after;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match_count = out_count_reg;

endmodule

`default_nettype wire

// File: rtl/core/nonoverlap_pattern_counter_core.sv
// Top level of the non-overlapping pattern counter.
// Depends on npc_pkg, npc_if, npc_front, npc_queue, npc_back.
//
//  channel   role    payload                                 word moves when
//  stream    sink    data_byte, byte_present, end_of_file    valid && ready
//  result    source  match_count                             valid && ready
//  cfg       sink    index, data                             valid && ready
//
// One stream word per cycle sustained while no end-of-file word waits on a
// stalled result; the back end does the byte compare and skip update as each
// byte pops. An end-of-file word passes through the holding stage, the queue
// and then the result register before its count shows.
// A stalled result blocks only an end-of-file word at the queue head and the
// words behind it; bytes ahead of it keep flowing, and the two-entry queue
// plus holding stage absorb the rest before ready drops.
// Reset clears all control state at once; no clearing pass. cfg.ready is
// always high.
`default_nettype none

module nonoverlap_pattern_counter_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    npc_stream_if.sink     stream,
    npc_result_if.source   result,
    npc_cfg_if.sink        cfg
);

    logic                     push;
    logic                     queue_full;
    logic                     pop;
    npc_pkg::npc_entry_t      push_entry;
    npc_pkg::npc_queue_out_t  head;

    npc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    npc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head)
    );

    npc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

// File: rtl/core/npc_checker.sv
// Port-level checks for the pattern counter, bound to the top level.
// Depends on npc_pkg and nonoverlap_pattern_counter_core.
`default_nettype none

module npc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        in_eof,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [npc_pkg::COUNT_W-1:0] out_count
);

    // End-of-file words held inside: holding stage, queue, result register
    localparam int CAPACITY = npc_pkg::QUEUE_DEPTH + 2;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       eof_in;
    logic       res_out;

    assign eof_in  = in_valid && in_ready && in_eof;
    assign res_out = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (eof_in && !res_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (res_out && !eof_in)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds its count
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count))
        else $error("result changed while stalled");

    // No result under reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // Every result answers an accepted end-of-file word
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without end of file");

    // The block never holds more end-of-file words than it has room for
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(CAPACITY))
        else $error("end-of-file words exceed capacity");

endmodule

bind nonoverlap_pattern_counter_core npc_checker u_npc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stream.valid),
    .in_ready  (stream.ready),
    .in_eof    (stream.end_of_file),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_count (result.match_count)
);

`default_nettype wire
